>>> hdl/r100_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r100_pkg : shared constants and helpers for the radix-100 float formatter
// ASCII codes, digit counts, form limits and narrow divide-by-ten helpers.
// ----------------------------------------------------------------------------
package r100_pkg;

  // Mantissa geometry: seven base-100 bytes, up to fourteen decimal digits.
  localparam int NUM_BYTES  = 7;
  localparam int NUM_DIGITS = 14;

  // Excess-64 exponent, doubled for decimal digits.
  localparam logic signed [9:0] EXP_OFFSET = 10'sd128;

  // Decimal exponent windows for plain and small forms.
  localparam logic signed [9:0] PLAIN_MAX_EX = 10'sd13;
  localparam logic signed [9:0] SMALL_MIN_EX = -10'sd6;

  // ASCII codes.
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_E     = 7'h65;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  typedef logic [4:0] digit_t;

  // Quotient by ten through a reciprocal, exact for all 9-bit inputs.
  function automatic logic [5:0] div10(input logic [8:0] x);
    logic [16:0] p;
    p = 17'(x) * 17'd205;
    return p[16:11];
  endfunction

  // Remainder by ten, given the quotient from div10.
  function automatic logic [3:0] rem10(input logic [8:0] x, input logic [5:0] q);
    logic [8:0] r;
    r = x - {q, 3'b000} - {2'b00, q, 1'b0};
    return r[3:0];
  endfunction

endpackage

>>> hdl/radix100_float_to_text_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix100_float_to_text_top : radix-100 float to ASCII text converter
// Splits an eight-byte radix-100 float into decimal digits and streams its
// text out, one character per transaction, flagging the final character.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (float_valid / float_stall / float_word): one transaction
//   carries one 64-bit float. float_stall is high whenever a number is in
//   work, so the block holds one number at a time.
//   Output channel (char_valid / char_stall / char_code / last_char): one
//   transaction per character; last_char marks the end of the number's text.
//   Digit split: after the input transaction, the mantissa bytes shift
//   through the divide-by-ten unit, one byte per cycle, into the digit
//   shift register; then one character leaves per cycle unless char_stall
//   holds the output register. A number has up to 21 characters; the next
//   input transaction waits for the byte-serial digit split and for the
//   last character to enter the output register. A zero first word skips
//   the digit split and gives the single character 0.
//   Stall: a high char_stall holds the output register and freezes the
//   character sequencer; nothing is lost or repeated.
//   Reset: rst (synchronous, active high) returns the sequencer to idle and
//   empties the output register.
// ----------------------------------------------------------------------------
module radix100_float_to_text_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        float_valid,
  output logic        float_stall,
  input  logic [63:0] float_word,
  output logic        char_valid,
  input  logic        char_stall,
  output logic [6:0]  char_code,
  output logic        last_char
);

  localparam logic [2:0] PREP_LAST = 3'(r100_pkg::NUM_BYTES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_ZERO, S_SIGN,
    S_PDIG, S_PDOT,
    S_S0, S_SDOT, S_SZER, S_SDIG,
    S_XLEAD, S_XDOT, S_XDIG, S_XE, S_XMINUS, S_XH, S_XT, S_XO
  } state_t;

  state_t state;

  // Working registers for the number in flight.
  logic                   neg;
  logic                   short_lead;   // first mantissa byte below ten
  logic signed [9:0]      ex;           // decimal exponent
  logic [55:0]            bsr;          // mantissa byte shift register
  r100_pkg::digit_t       dig [r100_pkg::NUM_DIGITS];
  logic [2:0]             pcnt;
  logic [3:0]             pos;
  logic [3:0]             last;
  logic                   has_nz;
  logic [3:0]             idx;
  logic [2:0]             zcnt;
  logic [8:0]             mag;
  logic [5:0]             mag_q;
  logic [3:0]             exp_o;
  logic [1:0]             exp_h;
  logic [3:0]             exp_t;

  // Input side: accept only while idle.
  logic        in_take;
  logic [15:0] word_in;
  logic [15:0] word_n;
  logic        neg_in;
  logic        short_in;
  logic signed [9:0] ex_in;

  assign float_stall = (state != S_IDLE);
  assign in_take     = float_valid && !float_stall;
  assign word_in     = float_word[63:48];
  assign neg_in      = word_in[15];
  assign word_n      = neg_in ? 16'(16'd0 - word_in) : word_in;
  assign short_in    = (word_n[7:0] < 8'd10);
  assign ex_in       = $signed({1'b0, word_n[15:8], 1'b0}) - r100_pkg::EXP_OFFSET
                       + $signed({9'd0, !short_in});

  // Byte split: head byte of the shift register into tens and ones.
  logic [7:0] head;
  logic [5:0] head_q;
  logic [4:0] tens;
  logic [3:0] ones;
  logic       tens_push;
  logic [3:0] pos_ones;

  assign head      = bsr[55:48];
  assign head_q    = r100_pkg::div10({1'b0, head});
  assign tens      = head_q[4:0];
  assign ones      = r100_pkg::rem10({1'b0, head}, head_q);
  assign tens_push = (pcnt != 3'd0) || !short_lead;
  assign pos_ones  = pos + 4'(tens_push);

  // Exponent magnitude split, settled over the first prep cycles.
  logic signed [9:0] ex_neg;
  logic [5:0]        mag_q_next;
  logic [5:0]        hq;

  assign ex_neg     = -ex;
  assign mag_q_next = r100_pkg::div10(mag);
  assign hq         = r100_pkg::div10({3'b000, mag_q});

  // Form selection and sequencing helpers.
  logic       is_plain;
  logic       is_small;
  logic [3:0] ex4;
  logic       dot_plain;
  logic [3:0] pend;
  logic       exp_ge100;
  logic       exp_ge10;
  logic [6:0] dig_char;
  state_t     form_first;
  state_t     exp_first;

  assign is_plain  = !ex[9] && (ex <= r100_pkg::PLAIN_MAX_EX);
  assign is_small  = ex[9] && (ex >= r100_pkg::SMALL_MIN_EX);
  assign ex4       = ex[3:0];
  assign dot_plain = has_nz && (last > ex4);
  assign pend      = dot_plain ? last : ex4;
  assign exp_ge100 = (exp_h != 2'd0);
  assign exp_ge10  = exp_ge100 || (exp_t != 4'd0);
  assign dig_char  = r100_pkg::CH_ZERO + {2'b00, dig[0]};

  always_comb begin
    if (is_plain) begin
      form_first = S_PDIG;
    end else if (is_small) begin
      form_first = S_S0;
    end else begin
      form_first = S_XLEAD;
    end
    if (exp_ge100) begin
      exp_first = S_XH;
    end else if (exp_ge10) begin
      exp_first = S_XT;
    end else begin
      exp_first = S_XO;
    end
  end

  // Character sequencer: what to emit from each state and where to go next.
  logic       adv;
  logic       em_on;
  logic [6:0] em_char;
  logic       em_last;
  logic       em_pop;
  logic       em_zdec;
  state_t     em_next;

  assign adv = !char_valid || !char_stall;

  always_comb begin
    em_on   = 1'b1;
    em_char = r100_pkg::CH_ZERO;
    em_last = 1'b0;
    em_pop  = 1'b0;
    em_zdec = 1'b0;
    em_next = state;
    unique case (state)
      S_IDLE, S_PREP: begin
        em_on = 1'b0;
      end
      S_ZERO: begin
        em_last = 1'b1;
        em_next = S_IDLE;
      end
      S_SIGN: begin
        em_char = r100_pkg::CH_MINUS;
        em_next = form_first;
      end
      S_PDIG: begin
        em_char = dig_char;
        em_pop  = 1'b1;
        if (idx == ex4 && dot_plain) begin
          em_next = S_PDOT;
        end else if (idx == pend) begin
          em_last = 1'b1;
          em_next = S_IDLE;
        end
      end
      S_PDOT: begin
        em_char = r100_pkg::CH_DOT;
        em_next = S_PDIG;
      end
      S_S0: begin
        em_next = S_SDOT;
      end
      S_SDOT: begin
        em_char = r100_pkg::CH_DOT;
        if (zcnt != 3'd0) begin
          em_next = S_SZER;
        end else if (has_nz) begin
          em_next = S_SDIG;
        end else begin
          em_last = 1'b1;
          em_next = S_IDLE;
        end
      end
      S_SZER: begin
        em_zdec = 1'b1;
        if (zcnt == 3'd1) begin
          if (has_nz) begin
            em_next = S_SDIG;
          end else begin
            em_last = 1'b1;
            em_next = S_IDLE;
          end
        end
      end
      S_SDIG: begin
        em_char = dig_char;
        em_pop  = 1'b1;
        if (idx == last) begin
          em_last = 1'b1;
          em_next = S_IDLE;
        end
      end
      S_XLEAD: begin
        em_char = dig_char;
        em_pop  = 1'b1;
        em_next = (has_nz && last != 4'd0) ? S_XDOT : S_XE;
      end
      S_XDOT: begin
        em_char = r100_pkg::CH_DOT;
        em_next = S_XDIG;
      end
      S_XDIG: begin
        em_char = dig_char;
        em_pop  = 1'b1;
        if (idx == last) begin
          em_next = S_XE;
        end
      end
      S_XE: begin
        em_char = r100_pkg::CH_E;
        em_next = ex[9] ? S_XMINUS : exp_first;
      end
      S_XMINUS: begin
        em_char = r100_pkg::CH_MINUS;
        em_next = exp_first;
      end
      S_XH: begin
        em_char = r100_pkg::CH_ZERO + {5'd0, exp_h};
        em_next = S_XT;
      end
      S_XT: begin
        em_char = r100_pkg::CH_ZERO + {3'd0, exp_t};
        em_next = S_XO;
      end
      S_XO: begin
        em_char = r100_pkg::CH_ZERO + {3'd0, exp_o};
        em_last = 1'b1;
        em_next = S_IDLE;
      end
      default: begin
        em_on   = 1'b0;
        em_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_valid <= 1'b0;
    end else begin
      // Output register: load a character or drop a taken one.
      if (adv) begin
        char_valid <= em_on;
        if (em_on) begin
          char_code <= em_char;
          last_char <= em_last;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            neg        <= neg_in;
            short_lead <= short_in;
            ex         <= ex_in;
            bsr        <= {word_n[7:0], float_word[47:0]};
            pcnt       <= 3'd0;
            pos        <= 4'd0;
            last       <= 4'd0;
            has_nz     <= 1'b0;
            idx        <= 4'd0;
            state      <= (word_in == 16'd0) ? S_ZERO : S_PREP;
          end
        end
        S_PREP: begin
          // Advance the byte line and push its digits into the digit line.
          bsr <= {bsr[47:0], 8'd0};
          if (pcnt == 3'd0 && short_lead) begin
            for (int j = 0; j < r100_pkg::NUM_DIGITS - 1; j++) begin
              dig[j] <= dig[j+1];
            end
            dig[r100_pkg::NUM_DIGITS-1] <= {1'b0, ones};
          end else if (pcnt == PREP_LAST && short_lead) begin
            for (int j = 0; j < r100_pkg::NUM_DIGITS - 3; j++) begin
              dig[j] <= dig[j+3];
            end
            dig[r100_pkg::NUM_DIGITS-3] <= tens;
            dig[r100_pkg::NUM_DIGITS-2] <= {1'b0, ones};
            dig[r100_pkg::NUM_DIGITS-1] <= '0;
          end else begin
            for (int j = 0; j < r100_pkg::NUM_DIGITS - 2; j++) begin
              dig[j] <= dig[j+2];
            end
            dig[r100_pkg::NUM_DIGITS-2] <= tens;
            dig[r100_pkg::NUM_DIGITS-1] <= {1'b0, ones};
          end
          // Track the last nonzero digit for trailing-zero stripping.
          if (ones != 4'd0) begin
            last   <= pos_ones;
            has_nz <= 1'b1;
          end else if (tens != 5'd0) begin
            last   <= pos;
            has_nz <= 1'b1;
          end
          pos <= pos_ones + 4'd1;
          // Exponent magnitude pipeline: magnitude, then ones, then tens/hundreds.
          mag   <= ex[9] ? ex_neg[8:0] : ex[8:0];
          mag_q <= mag_q_next;
          exp_o <= r100_pkg::rem10(mag, mag_q_next);
          exp_h <= hq[1:0];
          exp_t <= r100_pkg::rem10({3'b000, mag_q}, hq);
          zcnt  <= ~ex[2:0];
          pcnt  <= pcnt + 3'd1;
          if (pcnt == PREP_LAST) begin
            state <= neg ? S_SIGN : form_first;
          end
        end
        default: begin
          if (adv) begin
            state <= em_next;
            if (em_pop) begin
              for (int j = 0; j < r100_pkg::NUM_DIGITS - 1; j++) begin
                dig[j] <= dig[j+1];
              end
              dig[r100_pkg::NUM_DIGITS-1] <= '0;
              idx <= idx + 4'd1;
            end
            if (em_zdec) begin
              zcnt <= zcnt - 3'd1;
            end
          end
        end
      endcase
    end
  end

  // Prep always hands over to a character state.
  a_prep_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP && pcnt == PREP_LAST) |=> (state != S_PREP && state != S_IDLE))
    else $error("prep phase did not hand over to the character sequencer");

  // Fraction digits never run past the last nonzero digit.
  a_frac_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_XDIG || state == S_SDIG) |-> (has_nz && idx <= last))
    else $error("digit index beyond last nonzero digit");

  // Plain form never emits past its end index.
  a_plain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PDIG) |-> (idx <= pend))
    else $error("plain form digit index beyond end");

  // Small-form zero run is entered only with zeros left.
  a_zero_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_SZER) |-> (zcnt != 3'd0))
    else $error("small form zero run with empty count");

endmodule
